// ===== sv/crop_preview_overlay_top_assert.svh =====
// assertion macros for the overlay modules, included by cpo_shade only
`ifndef CROP_PREVIEW_OVERLAY_TOP_ASSERT_SVH
`define CROP_PREVIEW_OVERLAY_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// property checked outside reset
`define CPO_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// property checked during reset as well
`define CPO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`else

`define CPO_ASSERT(lbl, clk, rst, prop, msg)
`define CPO_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/cpo_pkg.sv =====
package cpo_pkg;

   // fixed field widths
   localparam int COORD_W  = 12;
   localparam int SAMPLE_W = 16;
   localparam int ANGLE_W  = 15;
   localparam int GAIN_W   = 9;

   // clamped rectangle size, wide enough for the largest size setting
   localparam int SIZE_W = 15;
   // half-pixel offset, signed
   localparam int DX_W   = 17;
   // offset times q1.14 angle
   localparam int PROD_W = DX_W + 16;
   // rotated local coordinate
   localparam int UV_W   = PROD_W + 1;
   // edge slack in half pixels times 2^14
   localparam int D_W    = UV_W + 1;
   localparam int Q_BITS = 14;

   // register indexes
   localparam logic [2:0] CSR_RECT_LEFT   = 3'd0;
   localparam logic [2:0] CSR_RECT_TOP    = 3'd1;
   localparam logic [2:0] CSR_RECT_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_RECT_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_COS_ANGLE   = 3'd4;
   localparam logic [2:0] CSR_SIN_ANGLE   = 3'd5;
   localparam logic [2:0] CSR_DIM_GAIN    = 3'd6;
   localparam logic [2:0] CSR_LINE_LEVEL  = 3'd7;

   // region codes
   localparam logic [1:0] REGION_INSIDE  = 2'd0;
   localparam logic [1:0] REGION_LINE    = 2'd1;
   localparam logic [1:0] REGION_OUTSIDE = 2'd2;

   typedef logic [3:0][SAMPLE_W-1:0] sample_vec_type;

   typedef struct packed {
      logic [COORD_W-1:0]  pix_x;
      logic [COORD_W-1:0]  pix_y;
      logic [SAMPLE_W-1:0] src_c0;
      logic [SAMPLE_W-1:0] src_c1;
      logic [SAMPLE_W-1:0] src_c2;
      logic [SAMPLE_W-1:0] src_c3;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] out_c0;
      logic [SAMPLE_W-1:0] out_c1;
      logic [SAMPLE_W-1:0] out_c2;
      logic [SAMPLE_W-1:0] out_c3;
      logic [1:0]          region;
   } rsp_type;

   // settings as held by the register file: sizes clamped, gain and level limited
   typedef struct packed {
      logic [COORD_W-1:0]        rect_left;
      logic [COORD_W-1:0]        rect_top;
      logic [SIZE_W-1:0]         rect_w;
      logic [SIZE_W-1:0]         rect_h;
      logic [ANGLE_W-1:0]        cos_angle;
      logic signed [ANGLE_W-1:0] sin_angle;
      logic [GAIN_W-1:0]         gain;
      logic [SAMPLE_W-1:0]       level;
   } cfg_type;

   // edge slacks and saturated samples between geometry and shading
   typedef struct packed {
      logic signed [D_W-1:0] du;
      logic signed [D_W-1:0] dv;
      sample_vec_type        smp;
   } geom_type;

endpackage

// ===== sv/cpo_geom.sv =====
module cpo_geom
   import cpo_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output geom_type out_data
);

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX =
      SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   sample_vec_type smp_in;
   sample_vec_type smp1_ff, smp2_ff, smp3_ff, smp4_ff;

   logic signed [DX_W-1:0]   dx_in, dy_in, dx_ff, dy_ff;
   logic signed [15:0]       ca, sa;
   logic signed [PROD_W-1:0] p_cx_ff, p_sy_ff, p_cy_ff, p_sx_ff;
   logic signed [UV_W-1:0]   u_in, v_in, u_ff, v_ff;
   logic signed [D_W-1:0]    wq, hq, u_ext, v_ext;
   logic signed [D_W-1:0]    du_in, dv_in, du_ff, dv_ff;

   // stage enables: a stage moves when empty or when its successor moves
   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // stage 1: saturate samples, half-pixel offsets from the centre
   always_comb begin
      smp_in[0] = (in_data.src_c0 > SAMPLE_MAX) ? SAMPLE_MAX : in_data.src_c0;
      smp_in[1] = (in_data.src_c1 > SAMPLE_MAX) ? SAMPLE_MAX : in_data.src_c1;
      smp_in[2] = (in_data.src_c2 > SAMPLE_MAX) ? SAMPLE_MAX : in_data.src_c2;
      smp_in[3] = (in_data.src_c3 > SAMPLE_MAX) ? SAMPLE_MAX : in_data.src_c3;
      dx_in = {4'b0, in_data.pix_x, 1'b0}
            - ({4'b0, cfg.rect_left, 1'b0} + {2'b0, cfg.rect_w});
      dy_in = {4'b0, in_data.pix_y, 1'b0}
            - ({4'b0, cfg.rect_top, 1'b0} + {2'b0, cfg.rect_h});
   end

   // angle operands as signed 16 bit
   assign ca = $signed({1'b0, cfg.cos_angle});
   assign sa = {cfg.sin_angle[ANGLE_W-1], cfg.sin_angle};

   // stage 3: rotated local coordinates
   assign u_in = {p_cx_ff[PROD_W-1], p_cx_ff} + {p_sy_ff[PROD_W-1], p_sy_ff};
   assign v_in = {p_cy_ff[PROD_W-1], p_cy_ff} - {p_sx_ff[PROD_W-1], p_sx_ff};

   // stage 4: slack against half width and half height, one add or subtract each
   assign wq    = $signed({{(D_W-SIZE_W-Q_BITS){1'b0}}, cfg.rect_w, {Q_BITS{1'b0}}});
   assign hq    = $signed({{(D_W-SIZE_W-Q_BITS){1'b0}}, cfg.rect_h, {Q_BITS{1'b0}}});
   assign u_ext = {{(D_W-UV_W){u_ff[UV_W-1]}}, u_ff};
   assign v_ext = {{(D_W-UV_W){v_ff[UV_W-1]}}, v_ff};
   assign du_in = u_ff[UV_W-1] ? (wq + u_ext) : (wq - u_ext);
   assign dv_in = v_ff[UV_W-1] ? (hq + v_ext) : (hq - v_ext);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en1) begin
         smp1_ff <= smp_in;
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
      end
      // stage 2: the four products
      if (en2) begin
         smp2_ff <= smp1_ff;
         p_cx_ff <= dx_ff * ca;
         p_sy_ff <= dy_ff * sa;
         p_cy_ff <= dy_ff * ca;
         p_sx_ff <= dx_ff * sa;
      end
      if (en3) begin
         smp3_ff <= smp2_ff;
         u_ff    <= u_in;
         v_ff    <= v_in;
      end
      if (en4) begin
         smp4_ff <= smp3_ff;
         du_ff   <= du_in;
         dv_ff   <= dv_in;
      end
   end

   assign out_valid    = v4_ff;
   assign out_data.du  = du_ff;
   assign out_data.dv  = dv_ff;
   assign out_data.smp = smp4_ff;

endmodule

// ===== sv/cpo_shade.sv =====
`include "crop_preview_overlay_top_assert.svh"

module cpo_shade
   import cpo_pkg::*;
#(
   parameter int CHANNELS   = 4,
   parameter int LINE_WIDTH = 3
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  geom_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_data
);

   localparam int LINE_W_EFF = (LINE_WIDTH < 1) ? 1 : LINE_WIDTH;
   localparam logic signed [D_W-1:0] LIM     = D_W'(LINE_W_EFF * (1 << Q_BITS));
   localparam logic signed [D_W-1:0] NEG_LIM = -LIM;

   logic           rv_ff, ov_ff;
   logic           en_r, en_c;
   logic           is_inside, is_outside;
   logic [1:0]     region_in, region_ff;
   sample_vec_type smp_ff;
   sample_vec_type res_in;
   rsp_type        rsp_ff;

   assign en_c     = !ov_ff || out_ready;
   assign en_r     = !rv_ff || en_c;
   assign in_ready = en_r;

   // region: the smaller slack against plus and minus half the line width
   assign is_inside  = (in_data.du > LIM) && (in_data.dv > LIM);
   assign is_outside = (in_data.du < NEG_LIM) || (in_data.dv < NEG_LIM);

   always_comb begin
      if (is_inside) begin
         region_in = REGION_INSIDE;
      end else if (is_outside) begin
         region_in = REGION_OUTSIDE;
      end else begin
         region_in = REGION_LINE;
      end
   end

   // colour per channel
   always_comb begin
      logic [SAMPLE_W+GAIN_W-1:0] prod;
      for (int c = 0; c < 4; c++) begin
         prod = smp_ff[c] * cfg.gain;
         case (region_ff)
            REGION_INSIDE: begin
               res_in[c] = smp_ff[c];
            end
            REGION_LINE: begin
               res_in[c] = ((c == 1) || (CHANNELS < 3)) ? cfg.level : '0;
            end
            default: begin
               res_in[c] = prod[SAMPLE_W+7:8];
            end
         endcase
         // alpha is kept on the line and outside
         if ((CHANNELS == 4) && (c == 3) && (region_ff != REGION_INSIDE)) begin
            res_in[c] = smp_ff[c];
         end
         if (c >= CHANNELS) begin
            res_in[c] = '0;
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         if (en_r) rv_ff <= in_valid;
         if (en_c) ov_ff <= rv_ff;
      end
   end

   // region stage and output register
   always_ff @(posedge clock) begin
      if (en_r) begin
         region_ff <= region_in;
         smp_ff    <= in_data.smp;
      end
      if (en_c) begin
         rsp_ff.out_c0 <= res_in[0];
         rsp_ff.out_c1 <= res_in[1];
         rsp_ff.out_c2 <= res_in[2];
         rsp_ff.out_c3 <= res_in[3];
         rsp_ff.region <= region_ff;
      end
   end

   assign out_valid = ov_ff;
   assign out_data  = rsp_ff;

   `CPO_ASSERT(a_take_to_region, clock, reset, in_valid && in_ready |=> rv_ff, "item lost entering region stage")
   `CPO_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rv_ff && !ov_ff, "stage valid after reset")
   `CPO_ASSERT(a_unused_zero, clock, reset, ov_ff |-> (CHANNELS > 3 || rsp_ff.out_c3 == '0) && (CHANNELS > 2 || rsp_ff.out_c2 == '0), "unused channel not zero")
   `CPO_ASSERT(a_line_level, clock, reset, ov_ff && rsp_ff.region == REGION_LINE && CHANNELS >= 2 |-> rsp_ff.out_c1 == cfg.level, "line colour wrong")

endmodule

// ===== sv/crop_preview_overlay_top.sv =====
// channel   direction  handshake              payload
// req_      in         req_valid / req_ready  req_data   (pixel position and samples)
// rsp_      out        rsp_valid / rsp_ready  rsp_data   (result samples and region)
// csr_      in         csr_wr_en              csr_index, csr_data (register write)
//
// one item per clock sustained while rsp_ready holds; six register stages from req to rsp
// stages: offsets, rotation products, local coordinates, edge slack, region, colour
// reset clears the stage valid bits and loads the register reset values
// a stalled rsp holds each full stage with no bubble after it, so bubbles close up
module crop_preview_overlay_top
   import cpo_pkg::*;
#(
   parameter int MAX_SIZE    = 4096,
   parameter int CHANNELS    = 4,
   parameter int LINE_WIDTH  = 3,
   parameter int SAMPLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_SIZE);
   localparam logic [SIZE_W-1:0] SIZE_RESET =
      SIZE_W'((MAX_SIZE < 4096) ? MAX_SIZE : 4096);
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX =
      SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);
   localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(256);

   cfg_type           cfg_in, cfg_ff;
   logic [SIZE_W-1:0] size_wr;
   logic [12:0]       size_raw;
   geom_type          geom_data;
   logic              geom_valid, geom_ready;

   // size written, clamped to one up to the largest size
   assign size_raw = csr_data[12:0];
   always_comb begin
      if (size_raw == '0) begin
         size_wr = SIZE_W'(1);
      end else if ({{(SIZE_W-13){1'b0}}, size_raw} > SIZE_MAX) begin
         size_wr = SIZE_MAX;
      end else begin
         size_wr = {{(SIZE_W-13){1'b0}}, size_raw};
      end
   end

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_RECT_LEFT:   cfg_in.rect_left = csr_data[COORD_W-1:0];
            CSR_RECT_TOP:    cfg_in.rect_top  = csr_data[COORD_W-1:0];
            CSR_RECT_WIDTH:  cfg_in.rect_w    = size_wr;
            CSR_RECT_HEIGHT: cfg_in.rect_h    = size_wr;
            CSR_COS_ANGLE:   cfg_in.cos_angle = csr_data[ANGLE_W-1:0];
            CSR_SIN_ANGLE:   cfg_in.sin_angle = csr_data[ANGLE_W-1:0];
            CSR_DIM_GAIN: begin
               cfg_in.gain = (csr_data[GAIN_W-1:0] > GAIN_MAX) ?
                             GAIN_MAX : csr_data[GAIN_W-1:0];
            end
            CSR_LINE_LEVEL: begin
               cfg_in.level = (csr_data > SAMPLE_MAX) ? SAMPLE_MAX : csr_data;
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rect_left <= '0;
         cfg_ff.rect_top  <= '0;
         cfg_ff.rect_w    <= SIZE_RESET;
         cfg_ff.rect_h    <= SIZE_RESET;
         cfg_ff.cos_angle <= ANGLE_W'(16384);
         cfg_ff.sin_angle <= '0;
         cfg_ff.gain      <= GAIN_W'(90);
         cfg_ff.level     <= SAMPLE_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // rotation and edge slack
   cpo_geom #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_geom (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (geom_valid),
      .out_ready (geom_ready),
      .out_data  (geom_data)
   );

   // region decision and colour
   cpo_shade #(
      .CHANNELS  (CHANNELS),
      .LINE_WIDTH(LINE_WIDTH)
   ) u_shade (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (geom_valid),
      .in_ready  (geom_ready),
      .in_data   (geom_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule
